/* rtl/tcgr_pkg.sv */
// Shared types, constants and helpers for the text console glyph renderer.
package tcgr_pkg;

  localparam int GlyphCountDef    = 256;
  localparam int MaxGlyphRowsDef  = 32;
  localparam int BytesPerPixelDef = 4;

  localparam logic [7:0]  NewlineCode   = 8'd10;
  localparam logic [11:0] CoordMax      = 12'hFFF;
  localparam logic [31:0] WhiteColour   = 32'h00FF_FFFF;
  localparam logic [5:0]  GlyphWidthMax = 6'd32;
  localparam int          RowCntW       = 6;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_LOAD_FONT  = 2'd1,
    OP_SET_CURSOR = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_GLYPH_ROW = 2'd0,
    KIND_SCROLL    = 2'd1,
    KIND_CLEAR     = 2'd2,
    KIND_STATUS    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_FONT_WIDTH    = 3'd0,
    REG_FONT_HEIGHT   = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_LINE_PITCH    = 3'd4,
    REG_SCROLL_ENABLE = 3'd5
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NL_SUM,
    S_NL_CHK,
    S_SETUP,
    S_OFFSET,
    S_NL_OUT,
    S_ROWS,
    S_STATUS,
    S_CLEAR
  } seq_state_e;

  typedef struct packed {
    logic [5:0]  font_width;
    logic [5:0]  font_height;
    logic [11:0] screen_width;
    logic [11:0] screen_height;
    logic [13:0] line_pitch;
    logic        scroll_enable;
  } cfg_t;

  typedef struct packed {
    logic [25:0] a;
    logic [25:0] b;
    logic [12:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [26:0] sum;
    logic        ge;
  } alu_rsp_t;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [25:0] byte_offset;
    logic [31:0] row_bits;
    logic [31:0] colour_out;
    logic [5:0]  scroll_rows;
    logic [11:0] cursor_x_now;
    logic [11:0] cursor_y_now;
    logic        last;
  } res_t;

  function automatic logic [11:0] sat12(input logic [12:0] v);
    return (v > {1'b0, CoordMax}) ? CoordMax : v[11:0];
  endfunction

endpackage

/* rtl/tcgr_if.sv */
// Channel interfaces: command items, result items and register writes.
interface tcgr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  char_code;
  logic [4:0]  glyph_row;
  logic [31:0] row_pattern;
  logic [11:0] set_x;
  logic [11:0] set_y;
  logic [31:0] colour_in;

  modport source (output valid, opcode, char_code, glyph_row, row_pattern, set_x, set_y,
                  colour_in, input ready);
  modport sink (input valid, opcode, char_code, glyph_row, row_pattern, set_x, set_y,
                colour_in, output ready);
endinterface

interface tcgr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [25:0] byte_offset;
  logic [31:0] row_bits;
  logic [31:0] colour_out;
  logic [5:0]  scroll_rows;
  logic [11:0] cursor_x_now;
  logic [11:0] cursor_y_now;
  logic        last;

  modport source (output valid, kind, pixel_x, pixel_y, byte_offset, row_bits, colour_out,
                  scroll_rows, cursor_x_now, cursor_y_now, last, input ready);
  modport sink (input valid, kind, pixel_x, pixel_y, byte_offset, row_bits, colour_out,
                scroll_rows, cursor_x_now, cursor_y_now, last, output ready);
endinterface

interface tcgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [13:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/tcgr_font_mem.sv */
// Glyph row store: one write port, one registered read port.
module tcgr_font_mem #(
  parameter int ADDR_W = 13
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [31:0]       wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [31:0]       rdata_o
);

  logic [31:0] mem_q [2**ADDR_W];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/tcgr_alu.sv */
// Shared adder with threshold compare, time-shared by the sequencer.
module tcgr_alu import tcgr_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [26:0] sum;

  assign sum       = {1'b0, req_i.a} + {1'b0, req_i.b};
  assign rsp_o.sum = sum;
  assign rsp_o.ge  = (sum >= {14'b0, req_i.c});

endmodule

/* rtl/tcgr_seq.sv */
// Command sequencer: cursor state, newline handling, glyph row emission, output register.
module tcgr_seq import tcgr_pkg::*; #(
  parameter int GLYPH_COUNT     = GlyphCountDef,
  parameter int MAX_GLYPH_ROWS  = MaxGlyphRowsDef,
  parameter int BYTES_PER_PIXEL = BytesPerPixelDef,
  localparam int CodeW = $clog2(GLYPH_COUNT),
  localparam int RowW  = $clog2(MAX_GLYPH_ROWS),
  localparam int AddrW = CodeW + RowW
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  tcgr_item_if.sink          item_i,
  tcgr_result_if.source      result_o,
  output alu_req_t           alu_req_o,
  input  alu_rsp_t           alu_rsp_i,
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_waddr_o,
  output logic [31:0]        mem_wdata_o,
  output logic [AddrW-1:0]   mem_raddr_o,
  input  logic [31:0]        mem_rdata_i
);

  seq_state_e state_q, state_d;

  logic [11:0] cursor_col_q, cursor_col_d;
  logic [11:0] cursor_row_q, cursor_row_d;
  logic [31:0] draw_colour_q, draw_colour_d;

  logic [7:0]         code_q, code_d;
  logic               code_ok_q, code_ok_d;
  logic               is_char_q, is_char_d;
  logic [31:0]        cin_q, cin_d;
  logic [12:0]        row_sum_q, row_sum_d;
  logic               nl_pend_q, nl_pend_d;
  kind_e              nl_kind_q, nl_kind_d;
  logic [11:0]        draw_col_q, draw_col_d;
  logic [11:0]        py_q, py_d;
  logic [25:0]        off_q, off_d;
  logic [25:0]        mult_q, mult_d;
  logic [RowCntW-1:0] dy_q, dy_d;
  logic [RowCntW-1:0] rd_dy;

  logic        out_valid_q, out_valid_d;
  res_t        out_q, res_w;
  logic        load;
  logic        out_free;
  logic        accept;

  logic [5:0]  ew;
  logic [5:0]  eh;
  logic [5:0]  h1;
  logic [31:0] mask;
  logic        row_last;
  logic [13:0] col_bytes;

  assign ew   = (cfg_i.font_width > GlyphWidthMax) ? GlyphWidthMax : cfg_i.font_width;
  assign eh   = (int'(cfg_i.font_height) > MAX_GLYPH_ROWS) ? RowCntW'(MAX_GLYPH_ROWS)
                                                            : cfg_i.font_height;
  assign h1   = eh + 6'd1;
  assign mask = (ew == 6'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> ew);

  assign row_last  = (dy_q == (eh - 6'd1));
  assign col_bytes = 14'(draw_col_q) * 14'(BYTES_PER_PIXEL);

  assign item_i.ready = (state_q == S_IDLE);
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;

  assign mem_we_o    = accept && (opcode_e'(item_i.opcode) == OP_LOAD_FONT)
                       && (int'(item_i.char_code) < GLYPH_COUNT)
                       && (int'(item_i.glyph_row) < MAX_GLYPH_ROWS);
  assign mem_waddr_o = {item_i.char_code[CodeW-1:0], item_i.glyph_row[RowW-1:0]};
  assign mem_wdata_o = item_i.row_pattern;
  assign mem_raddr_o = {code_q[CodeW-1:0], rd_dy[RowW-1:0]};

  always_comb begin
    state_d       = state_q;
    cursor_col_d  = cursor_col_q;
    cursor_row_d  = cursor_row_q;
    draw_colour_d = draw_colour_q;
    code_d        = code_q;
    code_ok_d     = code_ok_q;
    is_char_d     = is_char_q;
    cin_d         = cin_q;
    row_sum_d     = row_sum_q;
    nl_pend_d     = nl_pend_q;
    nl_kind_d     = nl_kind_q;
    draw_col_d    = draw_col_q;
    py_d          = py_q;
    off_d         = off_q;
    mult_d        = mult_q;
    dy_d          = dy_q;
    rd_dy         = dy_q;
    alu_req_o     = '0;
    load          = 1'b0;
    res_w         = '0;
    res_w.cursor_x_now = cursor_col_q;
    res_w.cursor_y_now = cursor_row_q;

    case (state_q)
      S_IDLE: begin
        // wrap test: col + width > screen width
        alu_req_o.a = 26'(cursor_col_q);
        alu_req_o.b = 26'(ew);
        alu_req_o.c = {1'b0, cfg_i.screen_width} + 13'd1;
        if (accept) begin
          code_d    = item_i.char_code;
          code_ok_d = (int'(item_i.char_code) < GLYPH_COUNT);
          cin_d     = item_i.colour_in;
          nl_pend_d = 1'b0;
          case (opcode_e'(item_i.opcode))
            OP_WRITE_CHAR: begin
              is_char_d = (item_i.char_code != NewlineCode);
              if (item_i.char_code == NewlineCode || alu_rsp_i.ge) begin
                state_d = S_NL_SUM;
              end else begin
                state_d = S_SETUP;
              end
            end
            OP_LOAD_FONT: begin
              state_d = S_STATUS;
            end
            OP_SET_CURSOR: begin
              cursor_col_d  = item_i.set_x;
              cursor_row_d  = item_i.set_y;
              draw_colour_d = item_i.colour_in;
              state_d       = S_STATUS;
            end
            OP_CLEAR: begin
              cursor_col_d = 12'd0;
              cursor_row_d = 12'd0;
              state_d      = S_CLEAR;
            end
            default: begin
              state_d = S_STATUS;
            end
          endcase
        end
      end

      S_NL_SUM: begin
        alu_req_o.a = 26'(cursor_row_q);
        alu_req_o.b = 26'(h1);
        row_sum_d   = alu_rsp_i.sum[12:0];
        state_d     = S_NL_CHK;
      end

      S_NL_CHK: begin
        // bottom test: row + 2 * line height >= screen height
        alu_req_o.a  = 26'(row_sum_q);
        alu_req_o.b  = 26'(h1);
        alu_req_o.c  = {1'b0, cfg_i.screen_height};
        cursor_col_d = 12'd0;
        if (alu_rsp_i.ge) begin
          nl_pend_d = 1'b1;
          if (cfg_i.scroll_enable) begin
            nl_kind_d = KIND_SCROLL;
          end else begin
            nl_kind_d    = KIND_CLEAR;
            cursor_row_d = 12'd0;
          end
        end else begin
          cursor_row_d = sat12(row_sum_q);
        end
        if (is_char_q) begin
          state_d = S_SETUP;
        end else if (alu_rsp_i.ge) begin
          state_d = S_NL_OUT;
        end else begin
          state_d = S_STATUS;
        end
      end

      S_SETUP: begin
        alu_req_o.a  = 26'(cursor_col_q);
        alu_req_o.b  = 26'(ew) + 26'd1;
        cursor_col_d = sat12(alu_rsp_i.sum[12:0]);
        draw_col_d   = cursor_col_q;
        py_d         = cursor_row_q;
        mult_d       = 26'(cursor_row_q) * 26'(cfg_i.line_pitch);
        dy_d         = '0;
        rd_dy        = '0;
        state_d      = S_OFFSET;
      end

      S_OFFSET: begin
        alu_req_o.a = mult_q;
        alu_req_o.b = 26'(col_bytes);
        off_d       = alu_rsp_i.sum[25:0];
        if (nl_pend_q) begin
          state_d = S_NL_OUT;
        end else if (eh == 6'd0) begin
          state_d = S_STATUS;
        end else begin
          state_d = S_ROWS;
        end
      end

      S_NL_OUT: begin
        res_w.kind        = nl_kind_q;
        res_w.scroll_rows = (nl_kind_q == KIND_SCROLL) ? h1 : 6'd0;
        res_w.last        = !(is_char_q && (eh != 6'd0));
        if (out_free) begin
          load    = 1'b1;
          state_d = res_w.last ? S_IDLE : S_ROWS;
        end
      end

      S_ROWS: begin
        alu_req_o.a       = off_q;
        alu_req_o.b       = 26'(cfg_i.line_pitch);
        res_w.kind        = KIND_GLYPH_ROW;
        res_w.pixel_x     = draw_col_q;
        res_w.pixel_y     = py_q;
        res_w.byte_offset = off_q;
        res_w.row_bits    = code_ok_q ? (mem_rdata_i & mask) : 32'h0;
        res_w.colour_out  = draw_colour_q;
        res_w.last        = row_last;
        if (out_free) begin
          load  = 1'b1;
          dy_d  = dy_q + 6'd1;
          rd_dy = dy_q + 6'd1;
          if (py_q != CoordMax) begin
            py_d  = py_q + 12'd1;
            off_d = alu_rsp_i.sum[25:0];
          end
          if (row_last) begin
            state_d = S_IDLE;
          end
        end
      end

      S_STATUS: begin
        res_w.kind       = KIND_STATUS;
        res_w.colour_out = draw_colour_q;
        res_w.last       = 1'b1;
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_CLEAR: begin
        res_w.kind       = KIND_CLEAR;
        res_w.colour_out = cin_q;
        res_w.last       = 1'b1;
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load || (out_valid_q && !result_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cursor_col_q  <= 12'd0;
      cursor_row_q  <= 12'd0;
      draw_colour_q <= WhiteColour;
      out_valid_q   <= 1'b0;
      nl_pend_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cursor_col_q  <= cursor_col_d;
      cursor_row_q  <= cursor_row_d;
      draw_colour_q <= draw_colour_d;
      out_valid_q   <= out_valid_d;
      nl_pend_q     <= nl_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    code_ok_q  <= code_ok_d;
    is_char_q  <= is_char_d;
    cin_q      <= cin_d;
    row_sum_q  <= row_sum_d;
    nl_kind_q  <= nl_kind_d;
    draw_col_q <= draw_col_d;
    py_q       <= py_d;
    off_q      <= off_d;
    mult_q     <= mult_d;
    dy_q       <= dy_d;
    if (load) begin
      out_q <= res_w;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.kind         = out_q.kind;
  assign result_o.pixel_x      = out_q.pixel_x;
  assign result_o.pixel_y      = out_q.pixel_y;
  assign result_o.byte_offset  = out_q.byte_offset;
  assign result_o.row_bits     = out_q.row_bits;
  assign result_o.colour_out   = out_q.colour_out;
  assign result_o.scroll_rows  = out_q.scroll_rows;
  assign result_o.cursor_x_now = out_q.cursor_x_now;
  assign result_o.cursor_y_now = out_q.cursor_y_now;
  assign result_o.last         = out_q.last;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !item_i.ready)
    else $error("sequencer ready straight after a transfer");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROWS) |-> (dy_q < eh))
    else $error("glyph row counter beyond font height");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && res_w.last) |=> (state_q == S_IDLE))
    else $error("final result loaded but sequencer not idle");

  a_nl_out_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NL_OUT) |-> nl_pend_q)
    else $error("newline result without pending scroll or clear");

endmodule

/* rtl/text_console_glyph_renderer_core.sv */
// Text console glyph renderer: top level with configuration registers.
//
// Channels: item_i takes command transfers (write char, load font row, set
// cursor, clear); result_o gives result transfers (glyph row, scroll, clear,
// cursor status), the final one of each command flagged by last; cfg_i takes
// register writes by index and is always ready.
// Timing: a command is taken only when the sequencer is idle. A printable
// character passes S_SETUP and S_OFFSET, then gives one glyph row per row of
// font_height capped at 32 (a status result if none); a line wrap adds S_NL_SUM
// and S_NL_CHK before, and S_NL_OUT after S_OFFSET when it scrolls or clears.
// Glyph rows leave at one per cycle while the output register is free, limited
// by the font store read port and the shared adder that steps the byte offset.
// Reset: cursor homes, draw colour goes white, registers take their reset
// values; the font store is not cleared and must be loaded before use.
// Stall: a result waits in the output register; the sequencer pauses until
// it is taken, so nothing is lost or repeated.
module text_console_glyph_renderer_core import tcgr_pkg::*; #(
  parameter int GLYPH_COUNT     = GlyphCountDef,
  parameter int MAX_GLYPH_ROWS  = MaxGlyphRowsDef,
  parameter int BYTES_PER_PIXEL = BytesPerPixelDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tcgr_item_if.sink     item_i,
  tcgr_result_if.source result_o,
  tcgr_cfg_if.sink      cfg_i
);

  localparam int AddrW = $clog2(GLYPH_COUNT) + $clog2(MAX_GLYPH_ROWS);

  cfg_t             cfg_q;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [31:0]      mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.font_width    <= 6'd8;
      cfg_q.font_height   <= 6'd16;
      cfg_q.screen_width  <= 12'd1024;
      cfg_q.screen_height <= 12'd768;
      cfg_q.line_pitch    <= 14'd4096;
      cfg_q.scroll_enable <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_FONT_WIDTH:    cfg_q.font_width    <= cfg_i.data[5:0];
        REG_FONT_HEIGHT:   cfg_q.font_height   <= cfg_i.data[5:0];
        REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_i.data[11:0];
        REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_i.data[11:0];
        REG_LINE_PITCH:    cfg_q.line_pitch    <= cfg_i.data;
        REG_SCROLL_ENABLE: cfg_q.scroll_enable <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  tcgr_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  tcgr_font_mem #(
    .ADDR_W (AddrW)
  ) u_font_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tcgr_seq #(
    .GLYPH_COUNT     (GLYPH_COUNT),
    .MAX_GLYPH_ROWS  (MAX_GLYPH_ROWS),
    .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .item_i      (item_i),
    .result_o    (result_o),
    .alu_req_o   (alu_req),
    .alu_rsp_i   (alu_rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
